### hw/rtl/hlcd_pkg.sv
// Types and constants shared by the header/length/checksum deframer.
`timescale 1ns / 1ps
`default_nettype none
package hlcd_pkg;

	// Frame layout
	localparam int unsigned MAX_FRAME      = 127;
	localparam int unsigned FRAME_OVERHEAD = 9;
	localparam int unsigned PAYLOAD_START  = 7;
	localparam int unsigned CHECK_TAIL     = 2;
	localparam int unsigned SYNC_COUNT     = 4;

	localparam logic [6:0] POS_HUNT   = 7'd0;
	localparam logic [6:0] POS_LENGTH = 7'd4;
	localparam logic [6:0] POS_SEQ    = 7'd5;
	localparam logic [6:0] POS_TYPE   = 7'd6;
	localparam logic [6:0] POS_BODY   = 7'd7;

	// Configuration register indexes
	localparam logic [7:0] CFG_SYNC_FIRST  = 8'd0;
	localparam logic [7:0] CFG_SYNC_SECOND = 8'd1;
	localparam logic [7:0] CFG_SYNC_THIRD  = 8'd2;
	localparam logic [7:0] CFG_SYNC_FOURTH = 8'd3;

	// Sync byte reset values: "head"
	localparam logic [7:0] SYNC_FIRST_RST  = 8'd104;
	localparam logic [7:0] SYNC_SECOND_RST = 8'd101;
	localparam logic [7:0] SYNC_THIRD_RST  = 8'd97;
	localparam logic [7:0] SYNC_FOURTH_RST = 8'd100;

	typedef enum logic [1:0] {
		ST_INCOMPLETE = 2'd0,
		ST_COMPLETE   = 2'd1,
		ST_INVALID    = 2'd2
	} frame_verdict_t;

	typedef enum logic [2:0] {
		ROLE_DISCARD = 3'd0,
		ROLE_HEADER  = 3'd1,
		ROLE_LENGTH  = 3'd2,
		ROLE_SEQ     = 3'd3,
		ROLE_TYPE    = 3'd4,
		ROLE_PAYLOAD = 3'd5,
		ROLE_CHECK   = 3'd6
	} role_t;

	typedef struct packed {
		frame_verdict_t status;
		role_t          role;
		logic [7:0]     value;
		logic [6:0]     pidx;
		logic [7:0]     sequence_b;
		logic [7:0]     type_b;
		logic [6:0]     length;
	} result_t;

endpackage
`default_nettype wire

### hw/rtl/header_length_checksum_deframer_unit.sv
// Sync-header, length and checksum deframer, one received byte per transfer.
`timescale 1ns / 1ps
`default_nettype none
// One byte enters per cycle while in_stall is low; the frame state (position,
// length, sequence, type, 16-bit sign-extended sum, checksum high byte) is
// updated by a single compare-and-add step in the cycle the byte is accepted,
// and its result is registered at the same edge, into the output register or,
// if that register is held by out_stall, into the skid entry.
// A one-entry skid register behind the output keeps in_stall registered, so
// the block sustains one byte per cycle whenever the sink keeps up and holds
// up to two results while out_stall is high. The four sync bytes are
// written through the cfg port (index 0..3, other indexes ignored), only
// while the stream is idle; the user is bound to this, the block does not enforce it.
module header_length_checksum_deframer_unit
	import hlcd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	// configuration
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	// input byte stream
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,
	// result stream
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [1:0]      frame_status,
	output logic [2:0]      byte_role,
	output logic [7:0]      byte_value,
	output logic [6:0]      payload_index,
	output logic [7:0]      frame_sequence,
	output logic [7:0]      frame_type,
	output logic [6:0]      frame_length
);

	logic [7:0]  sync_q [SYNC_COUNT];
	logic [6:0]  pos_q, pos_n;
	logic [6:0]  len_q, len_n;
	logic [7:0]  seq_q, seq_n;
	logic [7:0]  typ_q, typ_n;
	logic [15:0] sum_q, sum_n;
	logic [7:0]  chk_hi_q, chk_hi_n;

	result_t     res;
	result_t     out_q, skid_q;
	logic        out_valid_q, skid_valid_q;

	logic        accept_in;
	logic        out_free;
	logic [15:0] b_sext;
	logic [7:0]  tail_pos;
	logic [15:0] stored_chk;

	assign cfg_ready = 1'b1;
	assign in_stall  = skid_valid_q;
	assign accept_in = in_valid && !skid_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	// Sync byte registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q[0] <= SYNC_FIRST_RST;
			sync_q[1] <= SYNC_SECOND_RST;
			sync_q[2] <= SYNC_THIRD_RST;
			sync_q[3] <= SYNC_FOURTH_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SYNC_FIRST:  sync_q[0] <= cfg_data;
				CFG_SYNC_SECOND: sync_q[1] <= cfg_data;
				CFG_SYNC_THIRD:  sync_q[2] <= cfg_data;
				CFG_SYNC_FOURTH: sync_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Per-byte step: classify the byte and advance the frame state
	assign b_sext     = {{8{rx_byte[7]}}, rx_byte};
	assign tail_pos   = {1'b0, pos_q} + 8'(CHECK_TAIL);
	assign stored_chk = {chk_hi_q, rx_byte};

	always_comb begin
		pos_n    = pos_q;
		len_n    = len_q;
		seq_n    = seq_q;
		typ_n    = typ_q;
		sum_n    = sum_q;
		chk_hi_n = chk_hi_q;
		res.status = ST_INCOMPLETE;
		res.role   = ROLE_DISCARD;
		res.pidx   = '0;
		priority if (pos_q < POS_LENGTH) begin
			priority if (pos_q != POS_HUNT && rx_byte == sync_q[pos_q[1:0]]) begin
				res.role = ROLE_HEADER;
				sum_n    = sum_q + b_sext;
				pos_n    = pos_q + 7'd1;
			end else if (rx_byte == sync_q[0]) begin
				// a first sync byte opens a new frame
				res.role = ROLE_HEADER;
				len_n    = '0;
				seq_n    = '0;
				typ_n    = '0;
				chk_hi_n = '0;
				sum_n    = b_sext;
				pos_n    = 7'd1;
			end else begin
				pos_n = POS_HUNT;
			end
		end else if (pos_q == POS_LENGTH) begin
			res.role = ROLE_LENGTH;
			len_n    = rx_byte[6:0];
			if (rx_byte < 8'(FRAME_OVERHEAD) || rx_byte > 8'(MAX_FRAME)) begin
				res.status = ST_INVALID;
				pos_n      = POS_HUNT;
			end else begin
				sum_n = sum_q + b_sext;
				pos_n = POS_SEQ;
			end
		end else if (pos_q == POS_SEQ) begin
			res.role = ROLE_SEQ;
			seq_n    = rx_byte;
			sum_n    = sum_q + b_sext;
			pos_n    = POS_TYPE;
		end else if (pos_q == POS_TYPE) begin
			res.role = ROLE_TYPE;
			typ_n    = rx_byte;
			sum_n    = sum_q + b_sext;
			pos_n    = POS_BODY;
		end else if (tail_pos < {1'b0, len_q}) begin
			res.role = ROLE_PAYLOAD;
			res.pidx = pos_q - POS_BODY;
			sum_n    = sum_q + b_sext;
			pos_n    = pos_q + 7'd1;
		end else if (tail_pos == {1'b0, len_q}) begin
			res.role = ROLE_CHECK;
			chk_hi_n = rx_byte;
			pos_n    = pos_q + 7'd1;
		end else begin
			// last checksum byte closes the frame
			res.role   = ROLE_CHECK;
			res.status = (stored_chk == sum_q) ? ST_COMPLETE : ST_INVALID;
			pos_n      = POS_HUNT;
		end
		res.value      = rx_byte;
		res.sequence_b = seq_n;
		res.type_b     = typ_n;
		res.length     = len_n;
	end

	// Frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= POS_HUNT;
			len_q    <= '0;
			seq_q    <= '0;
			typ_q    <= '0;
			sum_q    <= '0;
			chk_hi_q <= '0;
		end else if (accept_in) begin
			pos_q    <= pos_n;
			len_q    <= len_n;
			seq_q    <= seq_n;
			typ_q    <= typ_n;
			sum_q    <= sum_n;
			chk_hi_q <= chk_hi_n;
		end
	end

	// Output register and skid entry: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || accept_in;
			skid_valid_q <= 1'b0;
		end else if (accept_in) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Output register and skid entry: payload
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept_in) begin
				out_q <= res;
			end
		end else if (accept_in) begin
			skid_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign frame_status   = out_q.status;
	assign byte_role      = out_q.role;
	assign byte_value     = out_q.value;
	assign payload_index  = out_q.pidx;
	assign frame_sequence = out_q.sequence_b;
	assign frame_type     = out_q.type_b;
	assign frame_length   = out_q.length;

`ifndef SYNTH
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry holds a result while the output register is empty");

	a_pos_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < 7'(MAX_FRAME))
		else $error("byte position ran past the longest frame");

	a_complete_on_check: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status == ST_COMPLETE |-> out_q.role == ROLE_CHECK)
		else $error("frame reported complete on a byte that is not a checksum byte");

	a_pidx_payload_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.role != ROLE_PAYLOAD |-> out_q.pidx == '0)
		else $error("payload index set on a byte outside the payload");

	a_hunt_after_close: assert property (@(posedge clk) disable iff (!arst_n)
		accept_in && pos_q >= POS_BODY && tail_pos > {1'b0, len_q} |=> pos_q == POS_HUNT)
		else $error("block did not return to hunting after the last checksum byte");
`endif

endmodule
`default_nettype wire

### bench/tb.sv
// Self-checking testbench for the sync-header / length / checksum deframer.
`timescale 1ns / 1ps

module tb
	import hlcd_pkg::*;
();

	localparam int          STALL_LIMIT  = 1000;
	localparam int          PHASE_BYTES  = 225;
	localparam int          DRAIN_CYCLES = 8;
	localparam logic [7:0]  CFG_UNMAPPED = 8'hFF;

	// Predicts one result per received byte and matches it against the output stream
	class deframe_scoreboard;
		logic [7:0]  sync_b [SYNC_COUNT];
		logic [6:0]  pos;
		logic [7:0]  len_b;
		logic [7:0]  seq_b;
		logic [7:0]  typ_b;
		logic [15:0] sum;
		logic [7:0]  chk_hi;
		result_t     pending_results [$];
		int          errors;
		int          n_checked;
		int          n_complete;
		int          n_invalid;

		function new();
			sync_b[0] = SYNC_FIRST_RST;
			sync_b[1] = SYNC_SECOND_RST;
			sync_b[2] = SYNC_THIRD_RST;
			sync_b[3] = SYNC_FOURTH_RST;
			pos = POS_HUNT;
			len_b = '0;
			seq_b = '0;
			typ_b = '0;
			sum = '0;
			chk_hi = '0;
			errors = 0;
			n_checked = 0;
			n_complete = 0;
			n_invalid = 0;
		endfunction

		function void set_sync(logic [7:0] idx, logic [7:0] val);
			if (idx < SYNC_COUNT)
				sync_b[idx] = val;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		// Advance the frame state by one accepted byte and queue its result
		function void take_byte(logic [7:0] b);
			result_t     r;
			int          p;
			logic [15:0] stored;
			p = pos;
			r.status = ST_INCOMPLETE;
			r.role = ROLE_DISCARD;
			r.value = b;
			r.pidx = '0;
			if (p < SYNC_COUNT) begin
				if (p != 0 && b == sync_b[p]) begin
					r.role = ROLE_HEADER;
					sum = sum + {{8{b[7]}}, b};
					pos = 7'(p + 1);
				end else if (b == sync_b[0]) begin
					// a byte equal to the first sync byte opens a new header unless it is the expected next sync byte
					r.role = ROLE_HEADER;
					len_b = '0;
					seq_b = '0;
					typ_b = '0;
					chk_hi = '0;
					sum = {{8{b[7]}}, b};
					pos = 7'd1;
				end else begin
					pos = POS_HUNT;
				end
			end else if (p == POS_LENGTH) begin
				r.role = ROLE_LENGTH;
				len_b = b;
				if (b < FRAME_OVERHEAD || b > MAX_FRAME) begin
					r.status = ST_INVALID;
					pos = POS_HUNT;
				end else begin
					sum = sum + {{8{b[7]}}, b};
					pos = POS_SEQ;
				end
			end else if (p == POS_SEQ) begin
				r.role = ROLE_SEQ;
				seq_b = b;
				sum = sum + {{8{b[7]}}, b};
				pos = POS_TYPE;
			end else if (p == POS_TYPE) begin
				r.role = ROLE_TYPE;
				typ_b = b;
				sum = sum + {{8{b[7]}}, b};
				pos = POS_BODY;
			end else if (p + CHECK_TAIL < len_b) begin
				r.role = ROLE_PAYLOAD;
				r.pidx = 7'(p - PAYLOAD_START);
				sum = sum + {{8{b[7]}}, b};
				pos = 7'(p + 1);
			end else if (p + CHECK_TAIL == len_b) begin
				r.role = ROLE_CHECK;
				chk_hi = b;
				pos = 7'(p + 1);
			end else begin
				// low checksum byte closes the frame
				stored = {chk_hi, b};
				r.role = ROLE_CHECK;
				r.status = (stored == sum) ? ST_COMPLETE : ST_INVALID;
				pos = POS_HUNT;
			end
			r.sequence_b = seq_b;
			r.type_b = typ_b;
			r.length = len_b[6:0];
			pending_results.push_back(r);
		endfunction

		function void field(string name, logic [7:0] want, logic [7:0] got);
			if (want !== got) begin
				if (errors < 30)
					$display("%0t: %s mismatch, expected %0d, actual %0d",
						$time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [1:0] st, logic [2:0] ro, logic [7:0] va,
				logic [6:0] pi, logic [7:0] sq, logic [7:0] ty, logic [6:0] ln);
			result_t e;
			if (pending_results.size() == 0) begin
				if (errors < 30)
					$display("%0t: unexpected result, expected none, actual byte %0d role %0d",
						$time, va, ro);
				errors++;
				return;
			end
			e = pending_results.pop_front();
			n_checked++;
			if (e.status == ST_COMPLETE)
				n_complete++;
			if (e.status == ST_INVALID)
				n_invalid++;
			field("frame_status", e.status, st);
			field("byte_role", e.role, ro);
			field("byte_value", e.value, va);
			field("payload_index", e.pidx, pi);
			field("frame_sequence", e.sequence_b, sq);
			field("frame_type", e.type_b, ty);
			field("frame_length", e.length, ln);
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] frame_status;
	logic [2:0] byte_role;
	logic [7:0] byte_value;
	logic [6:0] payload_index;
	logic [7:0] frame_sequence;
	logic [7:0] frame_type;
	logic [6:0] frame_length;

	deframe_scoreboard sb = new();

	logic [7:0] sync_now [SYNC_COUNT];
	int         send_idle_pct = 0;
	int         stall_pct = 0;
	int         bytes_sent = 0;
	int         quiet_cycles = 0;

	header_length_checksum_deframer_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.frame_status   (frame_status),
		.byte_role      (byte_role),
		.byte_value     (byte_value),
		.payload_index  (payload_index),
		.frame_sequence (frame_sequence),
		.frame_type     (frame_type),
		.frame_length   (frame_length)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Sink: random stall, check every result transfer
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
		if (arst_n && out_valid && !out_stall)
			sb.check_result(frame_status, byte_role, byte_value, payload_index,
				frame_sequence, frame_type, frame_length);
	end

	// Watchdog: too long without any transfer ends the run
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: timeout, no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("Verification failed");
			$finish;
		end
	end

	// One byte transfer, with random idle cycles ahead of it
	task automatic put_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.take_byte(b);
		bytes_sent++;
	endtask

	// Stop sending until every predicted result has come out
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_sync(idx, val);
		if (idx < SYNC_COUNT)
			sync_now[idx] = val;
	endtask

	task automatic load_sync(input logic [7:0] s0, input logic [7:0] s1,
			input logic [7:0] s2, input logic [7:0] s3);
		write_reg(CFG_SYNC_FIRST, s0);
		write_reg(CFG_SYNC_SECOND, s1);
		write_reg(CFG_SYNC_THIRD, s2);
		write_reg(CFG_SYNC_FOURTH, s3);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Header, length, then (if the length is legal) body and checksum
	task automatic send_frame(input int len, input logic [7:0] seq_v,
			input logic [7:0] typ_v, input bit bad_sum);
		logic [15:0] s;
		logic [7:0]  b;
		int          k;
		s = '0;
		for (k = 0; k < SYNC_COUNT; k++) begin
			put_byte(sync_now[k]);
			s = s + {{8{sync_now[k][7]}}, sync_now[k]};
		end
		b = len[7:0];
		put_byte(b);
		if (len < FRAME_OVERHEAD || len > MAX_FRAME)
			return;
		s = s + {{8{b[7]}}, b};
		put_byte(seq_v);
		s = s + {{8{seq_v[7]}}, seq_v};
		put_byte(typ_v);
		s = s + {{8{typ_v[7]}}, typ_v};
		for (k = 0; k < len - FRAME_OVERHEAD; k++) begin
			b = 8'($urandom);
			put_byte(b);
			s = s + {{8{b[7]}}, b};
		end
		if (bad_sum)
			s = s ^ 16'($urandom_range(16'hFFFF, 1));
		put_byte(s[15:8]);
		put_byte(s[7:0]);
	endtask

	// Mostly well-formed frames, some bad lengths, cut-off headers and line noise
	task automatic random_burst();
		int pick;
		int len;
		int k;
		int i;
		pick = $urandom_range(99);
		if (pick < 70) begin
			if ($urandom_range(9) == 0)
				len = $urandom_range(MAX_FRAME, 25);
			else
				len = $urandom_range(24, FRAME_OVERHEAD);
			send_frame(len, 8'($urandom), 8'($urandom), $urandom_range(6) == 0);
		end else if (pick < 80) begin
			if ($urandom_range(1) == 0)
				len = $urandom_range(FRAME_OVERHEAD - 1, 0);
			else
				len = $urandom_range(255, MAX_FRAME + 1);
			send_frame(len, 8'($urandom), 8'($urandom), 1'b0);
		end else if (pick < 90) begin
			k = $urandom_range(SYNC_COUNT - 1, 1);
			for (i = 0; i < k; i++)
				put_byte(sync_now[i]);
			put_byte(8'($urandom));
		end else begin
			repeat ($urandom_range(4, 1))
				put_byte(8'($urandom));
		end
	endtask

	initial begin
		int ph;
		int start_bytes;
		sync_now[0] = SYNC_FIRST_RST;
		sync_now[1] = SYNC_SECOND_RST;
		sync_now[2] = SYNC_THIRD_RST;
		sync_now[3] = SYNC_FOURTH_RST;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: hunting byte, broken header, header restart, bad lengths, empty payload
		put_byte("x");
		put_byte("h");
		put_byte("e");
		put_byte("x");
		put_byte("h");
		send_frame(FRAME_OVERHEAD - 1, 8'h00, 8'h00, 1'b0);
		send_frame(MAX_FRAME + 1, 8'h00, 8'h00, 1'b0);
		send_frame(FRAME_OVERHEAD, 8'h00, 8'hFF, 1'b0);

		// Random traffic over four handshake phases, new sync bytes before each phase after the first
		for (ph = 0; ph < 4; ph++) begin
			if (ph != 0) begin
				drain();
				case (ph)
					1: load_sync(8'h00, 8'hFF, 8'h00, 8'hFF);
					2: begin
						write_reg(CFG_UNMAPPED, 8'($urandom));
						load_sync(8'hAA, 8'hAA, 8'hAA, 8'hAA);
					end
					default: load_sync(8'hFF, 8'($urandom), 8'($urandom), 8'h00);
				endcase
			end
			case (ph)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 55; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 55; end
				default: begin send_idle_pct = 12; stall_pct = 12; end
			endcase
			start_bytes = bytes_sent;
			if (ph == 0 || ph == 2)
				send_frame(MAX_FRAME, 8'($urandom), 8'($urandom), 1'b0);
			while (bytes_sent - start_bytes < PHASE_BYTES) begin
				if ($urandom_range(49) == 0)
					drain();
				random_burst();
			end
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d bytes through four handshake phases and four sync settings.",
			bytes_sent);
		$display("Checked %0d results: %0d frames complete, %0d marked invalid.",
			sb.n_checked, sb.n_complete, sb.n_invalid);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/hlcd_pkg.sv
hw/rtl/header_length_checksum_deframer_unit.sv
bench/tb.sv
